// ===== rtl/core/ise_pkg.sv =====
// ----------------------------------------------------------------------------
// ise_pkg
// Shared constants and types of the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SHIFT_W   = 11;

    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = {SHIFT_W{1'b1}};

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [SHIFT_W-1:0]       shift_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    // Controls for the store memory, sent from the sequencer.
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        data_t wr_data;
        logic  rd_en;
        idx_t  rd_addr;
    } mem_ctl_t;

endpackage

// ===== rtl/core/ise_if.sv =====
// ----------------------------------------------------------------------------
// ise_in_if / ise_out_if
// Valid/ready channels for incoming values and outgoing sorted words.
// ----------------------------------------------------------------------------
interface ise_in_if;
    import ise_pkg::*;

    logic  valid;
    logic  ready;
    data_t value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ise_out_if;
    import ise_pkg::*;

    logic   valid;
    logic   ready;
    data_t  sorted_value;
    logic   last_out;
    shift_t shift_count;
    logic   overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output shift_count, output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input shift_count, input overflow, output ready);
endinterface

// ===== rtl/core/insertion_sort_engine.sv =====
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Stable insertion sort of one set of signed words held in a 64-entry RAM.
// ----------------------------------------------------------------------------
// Insertion scans down from the top: each scan step moves one larger entry up
// into the hole and reads the next one below, and the word fills the last hole.
// A word that arrives with the store full is dropped and sets the overflow flag.
// After the last word, each result is read, loaded and held until taken, and
// only then is the next one read. Reset clears the sequencer, last flag, hole,
// fill count, shift total, overflow flag, emit index and output valid bit; the
// RAM contents are not cleared, since only filled entries are ever read.
// ----------------------------------------------------------------------------
module insertion_sort_engine (
    input  logic clk,
    input  logic rst_n,
    ise_in_if.sink    samples,
    ise_out_if.source results
);
    import ise_pkg::*;

    // Sequencer state and the word being inserted.
    state_t state_reg, state_next;
    data_t  key_reg,   key_next;
    logic   last_reg,  last_next;

    // pos_reg is the hole that the key will fill; it walks down during the scan.
    cnt_t   pos_reg,   pos_next;
    cnt_t   fill_reg,  fill_next;
    shift_t shift_reg, shift_next;
    logic   ovf_reg,   ovf_next;
    idx_t   emit_reg,  emit_next;

    // Output register. The valid bit is control, the payload needs no reset.
    logic   out_valid_reg, out_valid_next;
    data_t  out_value_reg, out_value_next;
    logic   out_last_reg,  out_last_next;
    shift_t out_shift_reg, out_shift_next;
    logic   out_ovf_reg,   out_ovf_next;

    mem_ctl_t         mem_ctl;
    logic [DATA_W-1:0] rd_data;
    logic              greater;
    logic              in_fire;
    logic              out_fire;
    logic              emit_final;
    cnt_t              pos_m1;
    cnt_t              pos_m2;
    cnt_t              fill_m1;
    shift_t            shift_inc;

    ise_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (mem_ctl.wr_addr),
        .wr_data (mem_ctl.wr_data),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (mem_ctl.rd_addr),
        .rd_data (rd_data)
    );

    assign samples.ready        = (state_reg == ST_IDLE);
    assign in_fire              = samples.valid && samples.ready;
    assign out_fire             = results.valid && results.ready;

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.last_out     = out_last_reg;
    assign results.shift_count  = out_shift_reg;
    assign results.overflow     = out_ovf_reg;

    assign pos_m1     = pos_reg - cnt_t'(1);
    assign pos_m2     = pos_reg - cnt_t'(2);
    assign fill_m1    = fill_reg - cnt_t'(1);
    assign shift_inc  = (shift_reg == SHIFT_LIMIT) ? shift_reg : shift_reg + shift_t'(1);

    // The read data in the scan state is always the entry just below the hole.
    assign greater    = $signed(rd_data) > key_reg;
    assign emit_final = ({1'b0, emit_reg} == fill_m1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (fill_reg == cnt_t'(MAX_ITEMS))
                    begin
                        state_next = samples.last ? ST_EMIT_RD : ST_IDLE;
                    end
                    else if (fill_reg == cnt_t'(0))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (greater)
                begin
                    // The hole has reached the bottom: nothing left to compare.
                    if (pos_reg == cnt_t'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    state_next = emit_final ? ST_IDLE : ST_EMIT_LD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls. A shift writes the hole and reads two below it, so the
    // read never meets the write of the same cycle.
    always_comb
    begin
        mem_ctl.wr_en   = 1'b0;
        mem_ctl.wr_addr = pos_reg[IDX_W-1:0];
        mem_ctl.wr_data = key_reg;
        mem_ctl.rd_en   = 1'b0;
        mem_ctl.rd_addr = pos_m1[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (fill_reg != cnt_t'(MAX_ITEMS)) && (fill_reg != cnt_t'(0)))
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = fill_m1[IDX_W-1:0];
                end
            end
            ST_SCAN:
            begin
                mem_ctl.wr_en = 1'b1;
                if (greater)
                begin
                    mem_ctl.wr_data = rd_data;
                    if (pos_reg != cnt_t'(1))
                    begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = pos_m2[IDX_W-1:0];
                    end
                end
            end
            ST_PLACE:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            ST_EMIT_RD:
            begin
                mem_ctl.rd_en   = 1'b1;
                mem_ctl.rd_addr = emit_reg;
            end
            ST_EMIT_LD:
            begin
                mem_ctl.rd_en = 1'b0;
            end
            ST_EMIT_HOLD:
            begin
                // Fetch the next word as soon as the current one is taken.
                if (out_fire && !emit_final)
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = emit_reg + idx_t'(1);
                end
            end
            default:
            begin
                mem_ctl.rd_en = 1'b0;
            end
        endcase
    end

    // Datapath and bookkeeping registers.
    always_comb
    begin
        key_next       = key_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        shift_next     = shift_reg;
        ovf_next       = ovf_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_shift_next = out_shift_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next  = samples.value;
                    last_next = samples.last;
                    pos_next  = fill_reg;
                    if (fill_reg == cnt_t'(MAX_ITEMS))
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (greater)
                begin
                    pos_next   = pos_m1;
                    shift_next = shift_inc;
                end
                else
                begin
                    fill_next = fill_reg + cnt_t'(1);
                end
            end
            ST_PLACE:
            begin
                fill_next = fill_reg + cnt_t'(1);
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = $signed(rd_data);
                out_last_next  = emit_final;
                out_shift_next = shift_reg;
                out_ovf_next   = ovf_reg;
            end
            ST_EMIT_HOLD:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (emit_final)
                    begin
                        // The set is complete: start the next one from empty.
                        fill_next  = cnt_t'(0);
                        shift_next = shift_t'(0);
                        ovf_next   = 1'b0;
                        emit_next  = idx_t'(0);
                    end
                    else
                    begin
                        emit_next = emit_reg + idx_t'(1);
                    end
                end
            end
            default:
            begin
                emit_next = emit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            pos_reg       <= cnt_t'(0);
            fill_reg      <= cnt_t'(0);
            shift_reg     <= shift_t'(0);
            ovf_reg       <= 1'b0;
            emit_reg      <= idx_t'(0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            shift_reg     <= shift_next;
            ovf_reg       <= ovf_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_shift_reg <= out_shift_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

// ===== rtl/core/ise_ram.sv =====
// ----------------------------------------------------------------------------
// ise_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ise_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== test/ise_sort_checker.sv =====
// ----------------------------------------------------------------------------
// ise_sort_checker
// Watches both channels of the insertion sort engine, keeps its own sorted
// copy of each set and compares every outgoing word with the expected one.
// ----------------------------------------------------------------------------
module ise_sort_checker
    import ise_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ise_in_if    samples,
    ise_out_if   results,
    output int   mismatches,
    output int   outstanding,
    output int   words_checked
);

    typedef struct packed {
        data_t  sorted_value;
        logic   last_out;
        shift_t shift_count;
        logic   overflow;
    } sorted_word_t;

    data_t        order_store [MAX_ITEMS];
    int           held;
    shift_t       shifts_made;
    logic         dropped;
    sorted_word_t sorted_queue [$];

    // Stable insertion: only strictly larger entries move up.
    function automatic void insert_in_order(data_t v);
        int pos;
        pos = held;
        while (pos > 0 && order_store[pos-1] > v) begin
            order_store[pos] = order_store[pos-1];
            pos--;
            if (shifts_made != SHIFT_LIMIT)
            begin
                shifts_made++;
            end
        end
        order_store[pos] = v;
        held++;
    endfunction

    function automatic void release_sorted_set();
        sorted_word_t w;
        for (int k = 0; k < held; k++) begin
            w.sorted_value = order_store[k];
            w.last_out     = (k == held - 1);
            w.shift_count  = shifts_made;
            w.overflow     = dropped;
            sorted_queue.push_back(w);
        end
        held        = 0;
        shifts_made = '0;
        dropped     = 1'b0;
    endfunction

    function automatic int compare_word(sorted_word_t want);
        int errs;
        errs = 0;
        if (results.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   results.sorted_value);
            errs++;
        end
        if (results.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, results.last_out);
            errs++;
        end
        if (results.shift_count !== want.shift_count) begin
            $error("shift_count: expected %0d, got %0d", want.shift_count,
                   results.shift_count);
            errs++;
        end
        if (results.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, results.overflow);
            errs++;
        end
        return errs;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        int errs;
        errs = 0;
        if (!rst_n) begin
            sorted_queue.delete();
            held          = 0;
            shifts_made   = '0;
            dropped       = 1'b0;
            mismatches    <= 0;
            outstanding   <= 0;
            words_checked <= 0;
        end else begin
            // Outgoing words are checked before this edge's incoming word is
            // modeled, so a word that leaves too early finds nothing waiting.
            if (results.valid && results.ready) begin
                if (sorted_queue.size() == 0) begin
                    $error("sorted_value: expected no word, got %0d", results.sorted_value);
                    errs++;
                end else begin
                    errs += compare_word(sorted_queue.pop_front());
                end
                words_checked <= words_checked + 1;
            end
            if (samples.valid && samples.ready) begin
                if (held < MAX_ITEMS)
                begin
                    insert_in_order(samples.value);
                end
                else
                begin
                    dropped = 1'b1;
                end
                if (samples.last)
                begin
                    release_sorted_set();
                end
            end
            mismatches  <= mismatches + errs;
            outstanding <= sorted_queue.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives sets of signed words into the insertion sort engine and checks the
// sorted words that come back, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import ise_pkg::*;

    localparam data_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic clk;
    logic rst_n;

    ise_in_if  samples ();
    ise_out_if results ();

    int mismatches;
    int outstanding;
    int words_checked;

    // While steady is set, neither the sender nor the receiver idles.
    bit steady;
    int words_sent;
    int sets_sent;
    int overflow_sets;
    int random_words;

    insertion_sort_engine u_dut (
        .clk,
        .rst_n,
        .samples (samples),
        .results (results)
    );

    // The checker models the engine from what it sees on the channels and
    // reports its mismatch count and the number of words still due.
    ise_sort_checker u_check (
        .clk,
        .rst_n,
        .samples       (samples),
        .results       (results),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case the engine hangs.
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver stalls at random about one time in five, except in steady
    // stretches. Ready changes only at the falling edge.
    initial begin
        results.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            results.ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    // Offers one word and returns at the falling edge after it was taken.
    // Valid is left high so that a following word goes out back to back;
    // an idle gap lowers it at one falling edge and raises it at a later one.
    task automatic send_word(input data_t v, input logic is_last);
        if (!steady && $urandom_range(99) < 20) begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.value <= v;
        samples.last  <= is_last;
        do @(posedge clk); while (!samples.ready);
        @(negedge clk);
        words_sent++;
    endtask

    // A set is sent in order with the final word marked. Words beyond the
    // store depth are dropped by the engine, including a marked final one,
    // and the set must still come back with its overflow flag raised.
    task automatic send_set(input data_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
        begin
            send_word(vals[i], i == vals.size() - 1);
        end
        sets_sent++;
        if (vals.size() > MAX_ITEMS)
        begin
            overflow_sets++;
        end
    endtask

    // Holds the sender off until every sorted word already due has arrived.
    task automatic wait_drained();
        samples.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    // Small ranges give many equal keys, the extremes stress the signed
    // compare, and the rest spreads over the whole word.
    function automatic data_t pick_value();
        case ($urandom_range(3))
            0: return data_t'(int'($urandom_range(8)) - 4);
            1:
            begin
                case ($urandom_range(3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return WORD_MIN + 1;
                    default: return WORD_MAX - 1;
                endcase
            end
            default: return data_t'($urandom);
        endcase
    endfunction

    initial begin
        data_t  set_q [$];
        int     set_size;
        int     set_idx;
        longint level;

        rst_n          = 1'b0;
        samples.valid  = 1'b0;
        samples.value  = '0;
        samples.last   = 1'b0;
        steady         = 1'b0;
        words_sent     = 0;
        sets_sent      = 0;
        overflow_sets  = 0;
        random_words   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed sets: a single word at each extreme, mixed signs with
        // repeats, a fully descending run, a fully ascending run with no
        // shifts at all, and a run of equal keys.
        set_q = '{WORD_MAX};
        send_set(set_q);
        set_q = '{WORD_MIN};
        send_set(set_q);
        set_q = '{data_t'(0), data_t'(-1), data_t'(1), WORD_MIN, WORD_MAX, data_t'(-1),
                  data_t'(0)};
        send_set(set_q);
        set_q = '{WORD_MAX, data_t'(1), data_t'(0), data_t'(-1), WORD_MIN};
        send_set(set_q);
        set_q = '{WORD_MIN, data_t'(-1), data_t'(0), data_t'(1), WORD_MAX};
        send_set(set_q);
        set_q = '{data_t'(5), data_t'(5), data_t'(5)};
        send_set(set_q);

        // Let the engine empty out completely before the random part.
        wait_drained();

        // Random sets. Most are short; set 2 fills the store in strictly
        // descending order for the largest shift count, set 5 overruns the
        // store, and an occasional long set may overrun it as well.
        set_idx = 0;
        while (random_words < 300) begin
            set_q.delete();
            steady = (set_idx >= 6 && set_idx < 14);
            if (set_idx == 2) begin
                level = WORD_MAX;
                for (int i = 0; i < MAX_ITEMS; i++) begin
                    set_q.push_back(data_t'(level));
                    level -= $urandom_range(1, 60000000);
                end
            end else begin
                if (set_idx == 5)
                begin
                    set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                end
                else if ($urandom_range(14) == 0)
                begin
                    set_size = $urandom_range(40, MAX_ITEMS + 6);
                end
                else
                begin
                    set_size = $urandom_range(1, 12);
                end
                repeat (set_size) set_q.push_back(pick_value());
            end
            if ($urandom_range(7) == 0)
            begin
                wait_drained();
            end
            send_set(set_q);
            random_words += set_q.size();
            set_idx++;
        end
        steady = 1'b0;

        // Wait for the last sorted words, then let the clock run on so that any
        // stray word from the engine is still caught by the checker.
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d words in %0d sets, %0d of them longer than the store.",
                 words_sent, sets_sent, overflow_sets);
        $display("Checked %0d sorted words, %0d field mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ise_pkg.sv
rtl/core/ise_if.sv
rtl/core/ise_ram.sv
rtl/core/insertion_sort_engine.sv
test/ise_sort_checker.sv
test/tb.sv
